@@ hdl/xsmf_pkg.sv @@
// Shared types and constants for the xyz sliding median filter.
// Used by xsmf_axis and xyz_sliding_median_filter; depends on nothing else.
package xsmf_pkg;

   // Default sizing of the window and of the detection counter
   localparam int WINDOW_DEF    = 51;
   localparam int COUNT_CAP_DEF = 1001;

   // Field widths of the stream items
   localparam int COORD_W    = 32;
   localparam int DET_W      = 10;
   localparam int REQ_DATA_W = 3 * COORD_W;
   localparam int RSP_DATA_W = 112;
   localparam int RSP_PAD_W  = RSP_DATA_W - 3 * COORD_W - DET_W;

   typedef logic signed [COORD_W-1:0] coord_type;

   // Top level sequencer
   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_RUN,
      TOP_EMIT
   } top_state_type;

   // Per-axis sorted-window update sequencer
   typedef enum logic [2:0] {
      AX_IDLE,
      AX_OLD,
      AX_SWEEP,
      AX_TAIL,
      AX_MED,
      AX_DONE
   } axis_state_type;

   // Command from the top level to each axis unit
   typedef struct packed {
      logic start;
      logic full;
   } axis_cmd_type;

endpackage

@@ hdl/xsmf_axis.sv @@
// One axis of the median filter: history ring memory plus sorted window memory.
// A sweep over the sorted memory inserts the new value and, once the window is full, removes the oldest.
// Depends on xsmf_pkg.
module xsmf_axis #(
   parameter int WINDOW = xsmf_pkg::WINDOW_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  xsmf_pkg::axis_cmd_type     cmd,
   input  logic [$clog2(WINDOW)-1:0]  slot,
   input  logic [$clog2(WINDOW)-1:0]  fill,
   input  xsmf_pkg::coord_type        sample,
   output logic                       done,
   output xsmf_pkg::coord_type        median
);

   localparam int IW = $clog2(WINDOW);
   localparam logic [IW-1:0] LAST = IW'(WINDOW - 1);
   localparam logic [IW-1:0] MID  = IW'(WINDOW / 2);

   xsmf_pkg::coord_type hist_mem [WINDOW];
   xsmf_pkg::coord_type sort_mem [WINDOW];

   xsmf_pkg::axis_state_type state_ff, state_in;
   xsmf_pkg::coord_type      hist_rd_ff;
   xsmf_pkg::coord_type      sort_rd_ff;
   xsmf_pkg::coord_type      new_ff, new_in;
   xsmf_pkg::coord_type      old_ff, old_in;
   xsmf_pkg::coord_type      med_ff, med_in;
   logic [IW-1:0]            hole_ff, hole_in;
   logic [IW-1:0]            cur_ff, cur_in;
   logic                     found_ff, found_in;
   logic                     asc_ff, asc_in;

   logic                     sort_we;
   logic [IW-1:0]            sort_waddr;
   logic [IW-1:0]            sort_raddr;
   xsmf_pkg::coord_type      sort_wdata;
   logic                     is_last;
   logic                     move;
   logic [IW-1:0]            step;
   logic [IW-1:0]            first;

   // History ring: store the new sample, read the one it replaces
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         hist_mem[slot] <= sample;
      end
      hist_rd_ff <= hist_mem[slot];
   end

   // Sorted window: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (sort_we) begin
         sort_mem[sort_waddr] <= sort_wdata;
      end
      sort_rd_ff <= sort_mem[sort_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= xsmf_pkg::AX_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      new_ff   <= new_in;
      old_ff   <= old_in;
      med_ff   <= med_in;
      hole_ff  <= hole_in;
      cur_ff   <= cur_in;
      found_ff <= found_in;
      asc_ff   <= asc_in;
   end

   // Sequence: fetch oldest (window full only), sweep the sorted window moving entries into the hole,
   // drop the new value where it belongs, then read the middle entry
   always_comb begin
      state_in   = state_ff;
      new_in     = new_ff;
      old_in     = old_ff;
      med_in     = med_ff;
      hole_in    = hole_ff;
      cur_in     = cur_ff;
      found_in   = found_ff;
      asc_in     = asc_ff;
      sort_we    = 1'b0;
      sort_waddr = hole_ff;
      sort_wdata = new_ff;
      sort_raddr = cur_ff;
      done       = 1'b0;
      is_last    = asc_ff ? (cur_ff == LAST) : (cur_ff == '0);
      move       = asc_ff ? (sort_rd_ff <= new_ff) : (sort_rd_ff > new_ff);
      step       = asc_ff ? cur_ff + 1'b1 : cur_ff - 1'b1;
      first      = '0;

      unique case (state_ff)
         xsmf_pkg::AX_IDLE: begin
            if (cmd.start) begin
               new_in = sample;
               if (cmd.full) begin
                  state_in = xsmf_pkg::AX_OLD;
               end else begin
                  // Filling: insert only, hole starts past the last entry
                  found_in = 1'b1;
                  asc_in   = 1'b0;
                  hole_in  = fill;
                  if (fill == '0) begin
                     sort_we    = 1'b1;
                     sort_waddr = '0;
                     sort_wdata = sample;
                     state_in   = xsmf_pkg::AX_MED;
                  end else begin
                     sort_raddr = fill - 1'b1;
                     cur_in     = fill - 1'b1;
                     state_in   = xsmf_pkg::AX_SWEEP;
                  end
               end
            end
         end
         xsmf_pkg::AX_OLD: begin
            // Sweep up when the new value is not below the one leaving
            old_in     = hist_rd_ff;
            asc_in     = (hist_rd_ff <= new_ff);
            found_in   = 1'b0;
            first      = (hist_rd_ff <= new_ff) ? '0 : LAST;
            sort_raddr = first;
            cur_in     = first;
            state_in   = xsmf_pkg::AX_SWEEP;
         end
         xsmf_pkg::AX_SWEEP: begin
            if (!is_last) begin
               sort_raddr = step;
               cur_in     = step;
            end
            if (!found_ff) begin
               // Look for the entry that leaves the window
               if (sort_rd_ff == old_ff) begin
                  found_in = 1'b1;
                  hole_in  = cur_ff;
                  if (is_last) begin
                     state_in = xsmf_pkg::AX_TAIL;
                  end
               end else if (is_last) begin
                  state_in = xsmf_pkg::AX_MED;
               end
            end else begin
               sort_we = 1'b1;
               if (move) begin
                  sort_wdata = sort_rd_ff;
                  hole_in    = cur_ff;
                  if (is_last) begin
                     state_in = xsmf_pkg::AX_TAIL;
                  end
               end else begin
                  sort_wdata = new_ff;
                  state_in   = xsmf_pkg::AX_MED;
               end
            end
         end
         xsmf_pkg::AX_TAIL: begin
            sort_we  = 1'b1;
            state_in = xsmf_pkg::AX_MED;
         end
         xsmf_pkg::AX_MED: begin
            sort_raddr = MID;
            state_in   = xsmf_pkg::AX_DONE;
         end
         xsmf_pkg::AX_DONE: begin
            med_in   = sort_rd_ff;
            done     = 1'b1;
            state_in = xsmf_pkg::AX_IDLE;
         end
         default: begin
            state_in = xsmf_pkg::AX_IDLE;
         end
      endcase
   end

   assign median = med_ff;

endmodule

@@ hdl/xyz_sliding_median_filter.sv @@
// Sliding-window median of 3-D points: each finite item enters a window of WINDOW
// samples per axis, and once the window is full every finite item gives one result
// with the per-axis median and a saturating count of finite items. Non-finite items
// (tuser low) are taken while idle and change nothing. Each axis keeps its window
// twice in memory: a ring in arrival order and a sorted copy. A finite item must be
// finished before the next item can be taken; its run is set by the sweep over the
// sorted memory, one entry per cycle through its single read port; the three axes
// sweep in parallel. The result waits in an output register; while an earlier result
// still sits there unaccepted, a full-window item holds in its last cycle and the
// input stays stalled until the register frees.
// No clearing pass is needed after reset.
// Depends on xsmf_pkg and xsmf_axis.
module xyz_sliding_median_filter #(
   parameter int WINDOW    = xsmf_pkg::WINDOW_DEF,
   parameter int COUNT_CAP = xsmf_pkg::COUNT_CAP_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // x_sample [31:0], y_sample [63:32], z_sample [95:64]
   input  logic [xsmf_pkg::REQ_DATA_W-1:0]   req_tdata,
   // sample_finite
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // median_x [31:0], median_y [63:32], median_z [95:64], detections [105:96], zeros above
   output logic [xsmf_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int IW   = $clog2(WINDOW);
   localparam int CW   = $clog2(WINDOW + 1);
   localparam int CNTW = $clog2(COUNT_CAP + 1);
   localparam int CWD  = xsmf_pkg::COORD_W;

   xsmf_pkg::top_state_type state_ff, state_in;
   logic [CW-1:0]           fill_ff, fill_in;
   logic [IW-1:0]           ptr_ff, ptr_in;
   logic [CNTW-1:0]         cnt_ff, cnt_in;
   logic                    item_full_ff, item_full_in;
   logic [2:0]              done_ff, done_in;
   logic [xsmf_pkg::DET_W-1:0] det_item_ff, det_item_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   xsmf_pkg::coord_type     mx_ff, mx_in, my_ff, my_in, mz_ff, mz_in;
   logic [xsmf_pkg::DET_W-1:0] det_ff, det_in;

   xsmf_pkg::axis_cmd_type  cmd;
   logic [2:0]              done_vec;
   xsmf_pkg::coord_type     med_x, med_y, med_z;
   logic                    take;
   logic                    out_free;

   // Axis units
   xsmf_axis #(.WINDOW(WINDOW)) u_axis_x (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .slot   (ptr_ff),
      .fill   (fill_ff[IW-1:0]),
      .sample (req_tdata[CWD-1:0]),
      .done   (done_vec[0]),
      .median (med_x)
   );

   xsmf_axis #(.WINDOW(WINDOW)) u_axis_y (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .slot   (ptr_ff),
      .fill   (fill_ff[IW-1:0]),
      .sample (req_tdata[2*CWD-1:CWD]),
      .done   (done_vec[1]),
      .median (med_y)
   );

   xsmf_axis #(.WINDOW(WINDOW)) u_axis_z (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .slot   (ptr_ff),
      .fill   (fill_ff[IW-1:0]),
      .sample (req_tdata[3*CWD-1:2*CWD]),
      .done   (done_vec[2]),
      .median (med_z)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= xsmf_pkg::TOP_IDLE;
         fill_ff      <= '0;
         ptr_ff       <= '0;
         cnt_ff       <= '0;
         item_full_ff <= 1'b0;
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         ptr_ff       <= ptr_in;
         cnt_ff       <= cnt_in;
         item_full_ff <= item_full_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      det_item_ff <= det_item_in;
      mx_ff       <= mx_in;
      my_ff       <= my_in;
      mz_ff       <= mz_in;
      det_ff      <= det_in;
   end

   // Accept items, start the axis units, collect their results
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      ptr_in       = ptr_ff;
      cnt_in       = cnt_ff;
      item_full_in = item_full_ff;
      done_in      = done_ff | done_vec;
      det_item_in  = det_item_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      mz_in        = mz_ff;
      det_in       = det_ff;
      out_free     = !rsp_valid_ff || rsp_tready;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      take         = 1'b0;
      cmd.start    = 1'b0;
      cmd.full     = (fill_ff == CW'(WINDOW));

      unique case (state_ff)
         xsmf_pkg::TOP_IDLE: begin
            req_tready = 1'b1;
            take       = req_tvalid && req_tuser;
            if (take) begin
               cmd.start    = 1'b1;
               item_full_in = cmd.full;
               done_in      = '0;
               ptr_in       = (ptr_ff == IW'(WINDOW - 1)) ? '0 : ptr_ff + 1'b1;
               if (!cmd.full) begin
                  fill_in = fill_ff + 1'b1;
               end
               if (cnt_ff != CNTW'(COUNT_CAP)) begin
                  cnt_in = cnt_ff + 1'b1;
               end
               det_item_in = xsmf_pkg::DET_W'(cnt_in);
               state_in    = xsmf_pkg::TOP_RUN;
            end
         end
         xsmf_pkg::TOP_RUN: begin
            if (&done_ff) begin
               state_in = xsmf_pkg::TOP_EMIT;
            end
         end
         xsmf_pkg::TOP_EMIT: begin
            // Fill items end here; window items wait for the output register
            if (!item_full_ff) begin
               state_in = xsmf_pkg::TOP_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               mx_in        = med_x;
               my_in        = med_y;
               mz_in        = med_z;
               det_in       = det_item_ff;
               state_in     = xsmf_pkg::TOP_IDLE;
            end
         end
         default: begin
            state_in = xsmf_pkg::TOP_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{xsmf_pkg::RSP_PAD_W{1'b0}}, det_ff, mz_ff, my_ff, mx_ff};

   // Axis units finish only while an item is in flight
   assert property (@(posedge clock) disable iff (reset)
      (|done_vec) |-> (state_ff == xsmf_pkg::TOP_RUN))
      else $error("axis unit finished outside of a run");

   // While filling, the ring pointer tracks the fill level
   assert property (@(posedge clock) disable iff (reset)
      (fill_ff < CW'(WINDOW)) |-> (CW'(ptr_ff) == fill_ff))
      else $error("ring pointer out of step with fill level");

   // Detection count never passes its cap
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNTW'(COUNT_CAP))
      else $error("detection count above cap");

   // A result appears only after a full-window item
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == xsmf_pkg::TOP_EMIT) && $past(item_full_ff))
      else $error("result without a full window");

endmodule

@@ tb/sv/tb.sv @@
// Self-checking bench for xyz_sliding_median_filter: streams 3-D samples, predicts
// per-axis window medians and detection counts in a scoreboard class, checks results.
// Depends on xsmf_pkg and the filter RTL only.
module tb;
   import xsmf_pkg::*;

   localparam int WIN          = WINDOW_DEF;
   localparam int CAP          = COUNT_CAP_DEF;
   localparam int MID          = WIN / 2;
   localparam int DRAIN_CYCLES = 4 * (WIN + 7);
   localparam int STALL_CYCLES = 3000;

   localparam coord_type C_MIN = 32'sh8000_0000;
   localparam coord_type C_MAX = 32'sh7FFF_FFFF;

   // Value classes for the random coordinates
   typedef enum int {
      VAL_FULL,
      VAL_TIES,
      VAL_EXTREME,
      VAL_CLUSTER
   } value_mode_type;

   typedef struct {
      coord_type        mx;
      coord_type        my;
      coord_type        mz;
      logic [DET_W-1:0] det;
   } median_item_type;

   // Window predictor and store of expected medians
   class median_scoreboard;
      coord_type       win_x [WIN];
      coord_type       win_y [WIN];
      coord_type       win_z [WIN];
      int              fill;
      int              oldest;
      int              seen;
      int              error_count;
      median_item_type expected_medians [$];

      function new();
         fill        = 0;
         oldest      = 0;
         seen        = 0;
         error_count = 0;
      endfunction

      task report(input string msg);
         $display("MISMATCH: %s", msg);
         error_count++;
      endtask

      // Sort a copy of one axis and pick the middle entry
      function coord_type axis_median(input coord_type w [WIN]);
         coord_type s [WIN];
         coord_type k;
         int        j;
         s = w;
         for (int i = 1; i < WIN; i++) begin
            k = s[i];
            j = i;
            while (j > 0 && s[j-1] > k) begin
               s[j] = s[j-1];
               j--;
            end
            s[j] = k;
         end
         return s[MID];
      endfunction

      // Update the window for one accepted sample; queue a result once full
      task note_sample(input coord_type x, input coord_type y, input coord_type z,
                       input logic finite);
         median_item_type m;
         if (!finite) return;
         if (seen < CAP) seen++;
         if (fill < WIN) begin
            win_x[fill] = x;
            win_y[fill] = y;
            win_z[fill] = z;
            fill++;
            return;
         end
         win_x[oldest] = x;
         win_y[oldest] = y;
         win_z[oldest] = z;
         oldest = (oldest + 1 >= WIN) ? 0 : oldest + 1;
         m.mx  = axis_median(win_x);
         m.my  = axis_median(win_y);
         m.mz  = axis_median(win_z);
         m.det = seen[DET_W-1:0];
         expected_medians.insert(expected_medians.size(), m);
      endtask

      // Compare one accepted result with the oldest expectation
      task check_result(input logic [RSP_DATA_W-1:0] d);
         median_item_type m;
         coord_type       gx;
         coord_type       gy;
         coord_type       gz;
         if (expected_medians.size() == 0) begin
            report($sformatf("unexpected result 0x%h", d));
            return;
         end
         m  = expected_medians.pop_front();
         gx = d[COORD_W-1:0];
         gy = d[2*COORD_W-1:COORD_W];
         gz = d[3*COORD_W-1:2*COORD_W];
         if (gx !== m.mx) report($sformatf("median_x got %0d want %0d", gx, m.mx));
         if (gy !== m.my) report($sformatf("median_y got %0d want %0d", gy, m.my));
         if (gz !== m.mz) report($sformatf("median_z got %0d want %0d", gz, m.mz));
         if (d[3*COORD_W+DET_W-1:3*COORD_W] !== m.det)
            report($sformatf("detections got %0d want %0d",
                             d[3*COORD_W+DET_W-1:3*COORD_W], m.det));
         if (d[RSP_DATA_W-1:3*COORD_W+DET_W] !== '0)
            report($sformatf("padding bits not zero: 0x%h", d[RSP_DATA_W-1:3*COORD_W+DET_W]));
      endtask

      function int pending();
         return expected_medians.size();
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int  send_idle_pct = 26;
   int  recv_idle_pct = 60;
   bit  stall_pending = 1'b0;

   median_scoreboard sb = new();

   xyz_sliding_median_filter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watch both channels and feed the scoreboard
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_sample(req_tdata[COORD_W-1:0], req_tdata[2*COORD_W-1:COORD_W],
                           req_tdata[3*COORD_W-1:2*COORD_W], req_tuser);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata);
      end
   end

   // Receiver: random back-pressure, or a long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (stall_pending) begin
            stall_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (STALL_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   function automatic coord_type gen_coord(input value_mode_type mode, input coord_type base);
      case (mode)
         VAL_TIES: begin
            return $signed($urandom_range(6)) - 3;
         end
         VAL_EXTREME: begin
            case ($urandom_range(4))
               0: return C_MIN;
               1: return C_MAX;
               2: return 0;
               3: return -1;
               default: return 1;
            endcase
         end
         VAL_CLUSTER: begin
            return base + $signed($urandom_range(255)) - 128;
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   // Offer one item and hold it until the block takes it
   task automatic send_sample(input coord_type x, input coord_type y, input coord_type z,
                              input logic finite);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {z, y, x};
      req_tuser  <= finite;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Random samples until the given number of finite ones has gone in
   task automatic run_random(input int finite_target);
      int             finite_sent;
      int             n;
      value_mode_type mode;
      coord_type      base;
      logic           fin;
      finite_sent = 0;
      n           = 0;
      mode        = VAL_FULL;
      base        = 0;
      while (finite_sent < finite_target) begin
         if (n % 48 == 0) begin
            mode = value_mode_type'($urandom_range(3));
            base = $urandom;
         end
         fin = ($urandom_range(99) >= 15);
         send_sample(gen_coord(mode, base), gen_coord(mode, base), gen_coord(mode, base), fin);
         if (fin) finite_sent++;
         n++;
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, ignored non-finite items, part of the window fill
      send_sample(C_MIN, C_MAX, 0, 1'b1);
      send_sample(C_MAX, C_MIN, -1, 1'b1);
      send_sample(-1, -1, -1, 1'b0);
      send_sample(0, 0, 0, 1'b0);
      send_sample(C_MAX, C_MAX, C_MAX, 1'b0);
      send_sample(0, 1, -1, 1'b1);
      send_sample(1, 0, C_MIN, 1'b1);
      send_sample(-1, C_MAX, C_MAX, 1'b1);
      send_sample(C_MIN, C_MIN, C_MIN, 1'b1);
      send_sample(C_MAX, C_MAX, C_MAX, 1'b1);
      send_sample(C_MIN, C_MIN, C_MIN, 1'b0);
      send_sample(32'sh0001_0000, -32'sh0001_0000, 32'sh0000_8000, 1'b1);
      send_sample(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F, 1'b1);
      send_sample(32'shAAAA_AAAA, 32'sh5555_5555, 32'shF0F0_F0F0, 1'b1);
      send_sample(0, 0, 0, 1'b1);
      send_sample(0, 0, 0, 1'b1);
      send_sample(-1, 1, 0, 1'b0);
      send_sample(C_MIN + 1, C_MAX - 1, 2, 1'b1);

      // Random part in three idling phases
      run_random(450);
      send_idle_pct = 60;
      recv_idle_pct = 26;
      run_random(450);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_pending = 1'b1;
      run_random(450);
      req_tvalid <= 1'b0;

      // Drain outstanding results, then give the block time to settle
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.error_count == 0 && sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #20000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ files.f @@
hdl/xsmf_pkg.sv
hdl/xsmf_axis.sv
hdl/xyz_sliding_median_filter.sv
tb/sv/tb.sv
